>>> rtl/fpba_pkg.sv
`timescale 1ns / 1ps

package fpba_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  // item function codes
  localparam logic [1:0] FN_LOAD    = 2'd0;
  localparam logic [1:0] FN_REQ     = 2'd1;
  localparam logic [1:0] FN_RESTART = 2'd2;

  // selection rules, the unused code behaves as first fit
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_POLICY      = 2'd0;
  localparam logic [1:0] CFG_BLOCK_COUNT = 2'd1;

  localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  block_index;
    logic [15:0] size;
    logic        last_request;
  } in_req_t;

  typedef struct packed {
    logic       granted;
    logic [3:0] chosen_block;
    logic [7:0] request_number;
  } out_rsp_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                 active;
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] cap;
  } srch_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic                 ld_en;
    logic [3:0]           ld_idx;
    logic [SIZE_BITS-1:0] ld_size;
    logic                 restore;
    logic                 up_en;
    logic [IDX_W-1:0]     up_idx;
    logic [SIZE_BITS-1:0] sz;
    logic [1:0]           policy;
    logic [CNT_W-1:0]     used;
  } ctl_t;

  function automatic logic [SIZE_BITS-1:0] mask_size(input logic [15:0] s);
    logic [31:0] w;
    w = {16'd0, s};
    return w[SIZE_BITS-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] used_blocks(input logic [4:0] bc);
    logic [31:0] w;
    w = {27'd0, bc};
    if (w > 32'(NUM_BLOCKS)) begin
      return CNT_W'(NUM_BLOCKS);
    end
    return CNT_W'(w);
  endfunction

  function automatic logic [3:0] blk_field(input logic [IDX_W-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[3:0];
  endfunction

endpackage

>>> rtl/fit_policy_block_allocator_top.sv
`timescale 1ns / 1ps

// first / best / worst fit block allocator. each of the NUM_BLOCKS blocks
// lives in a cell of a row; a request sends a search token down the row, one
// cell per cycle, and each cell in use replaces the running candidate when its
// capacity fits and beats it under the current policy. when the token leaves
// the last cell the chosen block's capacity, if a block fits, is reduced and the
// response (granted, chosen_block, request_number) goes to the output register.
// a request occupies the block until its response is handed to the output
// register, through the walk along the cell row and any output stall; loads
// and restarts can be accepted back to back. configuration writes are always
// ready and must only be issued while no request is in flight.

module fit_policy_block_allocator_top import fpba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // item channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_req_t    in_req_i,
  // response channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_rsp_t   out_rsp_o,
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [1:0]           policy_q, policy_d;
  logic [4:0]           bcount_q, bcount_d;
  logic [7:0]           cnt_q, cnt_d;
  logic [SIZE_BITS-1:0] sz_q, sz_d;
  logic                 last_q, last_d;
  srch_t                launch_q, launch_d;
  out_rsp_t             res_q, res_d;
  out_rsp_t             out_rsp_q, out_rsp_d;
  logic                 out_valid_q, out_valid_d;

  logic  in_acc, cfg_acc, emerge;
  ctl_t  ctl;
  srch_t tok [NUM_BLOCKS+1];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // the token has walked past the last cell
  assign emerge = (state_q == ST_SEARCH) && tok[NUM_BLOCKS].active;

  // broadcast commands to the cell row
  always_comb begin
    ctl         = '0;
    ctl.ld_en   = in_acc && in_req_i.func == FN_LOAD;
    ctl.ld_idx  = in_req_i.block_index;
    ctl.ld_size = mask_size(in_req_i.size);
    ctl.restore = in_acc && in_req_i.func == FN_RESTART;
    ctl.up_en   = emerge && tok[NUM_BLOCKS].found;
    ctl.up_idx  = tok[NUM_BLOCKS].pick;
    ctl.sz      = sz_q;
    ctl.policy  = policy_q;
    ctl.used    = used_blocks(bcount_q);
  end

  assign tok[0] = launch_q;

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    fpba_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(g)),
      .ctl_i  (ctl),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  // configuration registers
  always_comb begin
    policy_d = policy_q;
    bcount_d = bcount_q;
    if (cfg_acc) begin
      unique case (cfg_index_i)
        CFG_POLICY:      policy_d = cfg_data_i[1:0];
        CFG_BLOCK_COUNT: bcount_d = cfg_data_i[4:0];
        default:         ;
      endcase
    end
  end

  // control: accept, search, hand off result
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sz_d        = sz_q;
    last_d      = last_q;
    launch_d    = '0;
    res_d       = res_q;
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req_i.func)
            FN_REQ: begin
              sz_d            = mask_size(in_req_i.size);
              last_d          = in_req_i.last_request;
              launch_d.active = 1'b1;
              state_d         = ST_SEARCH;
            end
            FN_RESTART: cnt_d = '0;
            default:    ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (emerge) begin
          res_d.granted        = tok[NUM_BLOCKS].found;
          res_d.chosen_block   = tok[NUM_BLOCKS].found ? blk_field(tok[NUM_BLOCKS].pick)
                                                       : 4'd0;
          res_d.request_number = cnt_q;
          cnt_d                = last_q ? 8'd0 : cnt_q + 8'd1;
          state_d              = ST_DONE;
        end
      end
      ST_DONE: begin
        // output register is free or being drained this cycle
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          out_rsp_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= POL_FIRST;
      bcount_q    <= BLOCK_COUNT_RST;
      cnt_q       <= '0;
      launch_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      policy_q    <= policy_d;
      bcount_q    <= bcount_d;
      cnt_q       <= cnt_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sz_q      <= sz_d;
    last_q    <= last_d;
    res_q     <= res_d;
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

>>> rtl/fpba_cell.sv
`timescale 1ns / 1ps

module fpba_cell import fpba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  ctl_t             ctl_i,
  input  srch_t            tok_i,
  output srch_t            tok_o
);

  logic [SIZE_BITS-1:0] loaded_q, loaded_d;
  logic [SIZE_BITS-1:0] cap_q, cap_d;
  srch_t                tok_q, tok_d;
  logic                 in_use, fits, better, take;

  always_comb begin
    in_use = 32'(idx_i) < 32'(ctl_i.used);
    fits   = cap_q >= ctl_i.sz;
    better = !tok_i.found
          || (ctl_i.policy == POL_BEST  && cap_q < tok_i.cap)
          || (ctl_i.policy == POL_WORST && cap_q > tok_i.cap);
    take   = tok_i.active && in_use && fits && better;

    tok_d = tok_i;
    if (take) begin
      tok_d.found = 1'b1;
      tok_d.pick  = idx_i;
      tok_d.cap   = cap_q;
    end
  end

  always_comb begin
    loaded_d = loaded_q;
    cap_d    = cap_q;
    priority if (ctl_i.ld_en && 32'(ctl_i.ld_idx) == 32'(idx_i)) begin
      loaded_d = ctl_i.ld_size;
      cap_d    = ctl_i.ld_size;
    end else if (ctl_i.restore) begin
      cap_d = loaded_q;
    end else if (ctl_i.up_en && ctl_i.up_idx == idx_i) begin
      cap_d = cap_q - ctl_i.sz;
    end else begin
      // no command for this cell, hold
      cap_d = cap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      cap_q    <= '0;
      tok_q    <= '0;
    end else begin
      loaded_q <= loaded_d;
      cap_q    <= cap_d;
      tok_q    <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/fpba_checker.sv
`timescale 1ns / 1ps

module fpba_checker import fpba_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input in_req_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_rsp_t out_rsp_o
);

  // a stalled response stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // refused request reports block zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.granted |-> out_rsp_o.chosen_block == 4'd0)
    else $error("refused request with nonzero block");

  // an accepted request holds off further items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.func == FN_REQ |=> in_stall_o)
    else $error("item accepted during search");

  // a new response only follows a search in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("response without a request");

endmodule

bind fit_policy_block_allocator_top fpba_checker u_fpba_checker (.*);

>>> dv/fit_policy_block_allocator_top_test.sv
`timescale 1ns / 1ps

module fit_policy_block_allocator_top_test;
  import fpba_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] FN_UNUSED  = 2'd3;
  localparam logic [1:0] POL_UNUSED = 2'd3;

  // an allocation walks the cell row, so settling waits past that walk
  localparam int SETTLE_CYCLES = NUM_BLOCKS + 8;
  localparam int HOLD_CYCLES   = 300;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i;
  logic     in_stall_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  out_rsp_t out_rsp_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  fit_policy_block_allocator_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // allocator shadow: block table, request counter and the two registers
  // ---------------------------------------------------------------------------
  logic [15:0] blk_loaded   [NUM_BLOCKS];
  logic [15:0] blk_capacity [NUM_BLOCKS];
  logic [7:0]  alloc_number;
  logic [1:0]  cur_policy;
  logic [4:0]  cur_block_count;

  // grants the block still owes us, oldest first
  out_rsp_t pending_grants[$];

  int  mismatch_count;
  bit  no_idle;       // suppresses random gaps on both sides
  bit  hold_request;  // asks the response side for one long hold-off
  int  hold_left;

  initial begin
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      blk_loaded[k]   = '0;
      blk_capacity[k] = '0;
    end
    alloc_number    = '0;
    cur_policy      = POL_FIRST;
    cur_block_count = BLOCK_COUNT_RST;
    mismatch_count  = 0;
    no_idle         = 1'b0;
    hold_request    = 1'b0;
    hold_left       = 0;
  end

  // applies one accepted request to the shadow and queues the grant it causes
  task automatic predict_allocation(input in_req_t r);
    int         in_use;
    bit         hit;
    logic [3:0] pick;
    out_rsp_t   grant;
    hit  = 1'b0;
    pick = '0;
    case (r.func)
      FN_LOAD: begin
        blk_loaded[r.block_index]   = r.size;
        blk_capacity[r.block_index] = r.size;
      end
      FN_RESTART: begin
        blk_capacity = blk_loaded;
        alloc_number = '0;
      end
      FN_REQ: begin
        // oversized block counts saturate at the table size
        in_use = (cur_block_count > NUM_BLOCKS) ? NUM_BLOCKS : cur_block_count;
        for (int k = 0; k < in_use; k++) begin
          if (blk_capacity[k] >= r.size) begin
            if (!hit) begin
              hit  = 1'b1;
              pick = k[3:0];
            end else if (cur_policy == POL_BEST && blk_capacity[k] < blk_capacity[pick]) begin
              pick = k[3:0];
            end else if (cur_policy == POL_WORST && blk_capacity[k] > blk_capacity[pick]) begin
              pick = k[3:0];
            end
            // first fit and the unused policy code never replace the first hit
          end
        end
        if (hit) begin
          blk_capacity[pick] = blk_capacity[pick] - r.size;
        end
        grant.granted        = hit;
        grant.chosen_block   = hit ? pick : 4'd0;
        grant.request_number = alloc_number;
        pending_grants.push_back(grant);
        // a final allocation clears the count, capacities stay as they are
        alloc_number = r.last_request ? 8'd0 : alloc_number + 8'd1;
      end
      default: begin
        // unused function code: nothing happens
      end
    endcase
  endtask

  // input monitor, sampled on the edge with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_allocation(in_req_i);
    end
  end

  // ---------------------------------------------------------------------------
  // response check
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string field, input int want, input int got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_grants.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected response, expected none actual %0h", $time, out_rsp_o);
      end else begin
        want = pending_grants.pop_front();
        if (out_rsp_o.granted !== want.granted) begin
          note_mismatch("granted", want.granted, out_rsp_o.granted);
        end
        if (out_rsp_o.chosen_block !== want.chosen_block) begin
          note_mismatch("chosen_block", want.chosen_block, out_rsp_o.chosen_block);
        end
        if (out_rsp_o.request_number !== want.request_number) begin
          note_mismatch("request_number", want.request_number, out_rsp_o.request_number);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // response side: random stalls, or one long hold-off on demand
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!no_idle && $urandom_range(99) < 8) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  function automatic in_req_t make_item(input logic [1:0] func, input logic [3:0] idx,
                                        input logic [15:0] size, input logic last);
    in_req_t r;
    r.func         = func;
    r.block_index  = idx;
    r.size         = size;
    r.last_request = last;
    return r;
  endfunction

  // offers one request and returns on the edge that takes it
  task automatic send_item(input in_req_t r);
    if (!no_idle && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering, let every owed grant arrive, then let the cell row drain
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes both registers back to back while the block is idle
  task automatic configure(input logic [1:0] policy, input logic [4:0] count);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_POLICY;
    cfg_data_i  <= {6'd0, policy};
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_policy = policy;
    cfg_index_i <= CFG_BLOCK_COUNT;
    cfg_data_i  <= {3'd0, count};
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_block_count = count;
    cfg_valid_i <= 1'b0;
  endtask

  // mostly allocations with sizes that usually fit, plus loads, restarts, noise
  function automatic in_req_t random_item(input int last_pct, input int restart_pct);
    in_req_t r;
    int      roll;
    r.block_index  = 4'($urandom_range(15));
    r.size         = 16'($urandom);
    r.last_request = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (roll < restart_pct) begin
      r.func = FN_RESTART;
    end else if (roll < restart_pct + 3) begin
      r.func = FN_UNUSED;
    end else if (roll < restart_pct + 25) begin
      r.func = FN_LOAD;
      if ($urandom_range(1) == 0) begin
        r.size = 16'($urandom_range(64, 4096));
      end
    end else begin
      r.func = FN_REQ;
      roll = $urandom_range(99);
      if (roll < 10) begin
        r.size = 16'd0;
      end else if (roll >= 20) begin
        r.size = 16'($urandom_range(1, 600));
      end
      r.last_request = ($urandom_range(99) < last_pct);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty table, full-range sizes, refusals, the unused code, final and restart
  task automatic test_edge_items();
    configure(POL_FIRST, 5'd16);
    send_item(make_item(FN_REQ, 4'd9, 16'h0000, 1'b0));     // zero size fits an empty block
    send_item(make_item(FN_REQ, 4'd0, 16'h0001, 1'b0));     // nothing fits
    send_item(make_item(FN_LOAD, 4'd0, 16'hFFFF, 1'b0));
    send_item(make_item(FN_LOAD, 4'd15, 16'h8000, 1'b1));
    send_item(make_item(FN_LOAD, 4'd7, 16'h0001, 1'b0));
    send_item(make_item(FN_LOAD, 4'd10, 16'h5555, 1'b0));
    send_item(make_item(FN_REQ, 4'd15, 16'hFFFF, 1'b0));    // takes all of block 0
    send_item(make_item(FN_REQ, 4'd0, 16'hFFFF, 1'b0));     // refused, capacities unchanged
    send_item(make_item(FN_REQ, 4'd0, 16'h0001, 1'b0));
    send_item(make_item(FN_UNUSED, 4'd15, 16'hFFFF, 1'b1)); // ignored entirely
    send_item(make_item(FN_REQ, 4'd5, 16'h8000, 1'b1));     // final allocation clears count
    send_item(make_item(FN_REQ, 4'd0, 16'h0000, 1'b0));
    send_item(make_item(FN_RESTART, 4'd3, 16'hAAAA, 1'b1));
    send_item(make_item(FN_REQ, 4'd0, 16'hAAAA, 1'b0));
  endtask

  // each policy against a small table with a tie, then an empty block range
  task automatic test_policy_choice();
    send_item(make_item(FN_LOAD, 4'd2, 16'd100, 1'b0));
    send_item(make_item(FN_LOAD, 4'd5, 16'd40, 1'b0));
    send_item(make_item(FN_LOAD, 4'd9, 16'd40, 1'b0));
    configure(POL_BEST, 5'd16);
    send_item(make_item(FN_REQ, 4'd0, 16'd30, 1'b0));
    send_item(make_item(FN_REQ, 4'd0, 16'd35, 1'b0));
    configure(POL_WORST, 5'd16);
    send_item(make_item(FN_REQ, 4'd0, 16'd30, 1'b0));
    configure(POL_UNUSED, 5'd6);
    send_item(make_item(FN_REQ, 4'd0, 16'd30, 1'b0));
    configure(POL_FIRST, 5'd0);
    send_item(make_item(FN_REQ, 4'd0, 16'd0, 1'b0));        // no block in use
  endtask

  // response side holds off for a long stretch while allocations keep coming
  task automatic test_output_backpressure();
    configure(POL_BEST, 5'd16);
    hold_request = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_item(random_item(3, 0));
    end
  endtask

  task automatic run_phase(input logic [1:0] policy, input logic [4:0] count,
                           input int last_pct, input int restart_pct, input int items);
    configure(policy, count);
    for (int n = 0; n < items; n++) begin
      send_item(random_item(last_pct, restart_pct));
    end
  endtask

  // sweeps policies and block counts; one long quiet phase lets the count wrap
  task automatic test_random_traffic();
    run_phase(POL_FIRST, 5'd16, 3, 3, 150);
    run_phase(POL_BEST, 5'd16, 3, 3, 150);
    run_phase(POL_WORST, 5'd16, 3, 3, 130);
    run_phase(POL_UNUSED, 5'd5, 5, 3, 130);
    run_phase(POL_BEST, 5'd1, 3, 3, 100);
    no_idle = 1'b1;
    run_phase(POL_WORST, 5'd31, 0, 0, 420);
    no_idle = 1'b0;
    run_phase(POL_FIRST, 5'd0, 3, 3, 40);
    run_phase(2'($urandom_range(3)), 5'($urandom_range(1, 16)), 3, 3, 150);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_POLICY;
    cfg_data_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_items();
    test_policy_choice();
    test_output_backpressure();
    test_random_traffic();
    settle();

    if (mismatch_count == 0) begin
      $display("[fit_policy_block_allocator_top] OK");
    end else begin
      $display("[fit_policy_block_allocator_top] ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("[fit_policy_block_allocator_top] ERROR");
    $finish;
  end

endmodule
